// ===== sv/rpf_pkg.sv =====
// Shared types, constants and CRC helpers for the radio packet framer.
package rpf_pkg;

  localparam int MAX_PAYLOAD = 64;
  localparam int LEN_W = 7;
  localparam int ADDR_W = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0] WHITE_MASK = 8'h55;
  localparam logic [7:0] POSTAMBLE = 8'hAA;
  localparam logic [1:0] WHITE_ON = 2'd2;

  typedef enum logic [1:0] {
    REG_GROUP = 2'd0,
    REG_NODE  = 2'd1,
    REG_WHITE = 2'd2,
    REG_LEN   = 2'd3
  } reg_idx_t;

  typedef enum logic [6:0] {
    PH_HEAD  = 7'b0000001,
    PH_LEN   = 7'b0000010,
    PH_DATA  = 7'b0000100,
    PH_CRCL  = 7'b0001000,
    PH_CRCH  = 7'b0010000,
    PH_POST1 = 7'b0100000,
    PH_POST2 = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [7:0]       data;
    logic             first;
    logic             last;
    logic [4:0]       node;
    logic [LEN_W-1:0] len;
  } rpf_entry_t;

  function automatic logic [15:0] crc_fold(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] v;
    v = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (v[0]) begin
        v = (v >> 1) ^ CRC_POLY;
      end else begin
        v = v >> 1;
      end
    end
    return v;
  endfunction

  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] l);
    logic [LEN_W-1:0] r;
    r = l;
    if (l == '0) begin
      r = LEN_W'(1);
    end else if (l > LEN_W'(MAX_PAYLOAD)) begin
      r = LEN_W'(MAX_PAYLOAD);
    end
    return r;
  endfunction

endpackage

// ===== sv/radio_packet_framer_crc16.sv =====
// Top level of the radio packet framer: configuration registers and datapath wiring.
//
// Payload bytes enter on the in_ channel (in_valid, in_stall, in_payload_byte) and frame
// bytes leave on the out_ channel (out_valid, out_stall, out_frame_byte, out_frame_end).
// An item is taken at a clock edge where valid is high and stall is low.
// The first payload byte of a frame yields the node byte, the length byte and the byte
// itself; the last yields the byte, the CRC low and high bytes and two postamble bytes,
// with out_frame_end set on the final one. Other payload bytes yield one frame byte.
// Each item is written into the queue, and its first result is then registered at the output.
// The sequencer emits one frame byte per cycle unless out_stall holds it, so middle
// payload bytes sustain one item per cycle; a frame of N payload bytes is N + 6 bytes.
// A four-item queue lets the input keep flowing while the output is stalled; in_stall
// rises only when that queue is full, and a stalled output holds its byte.
// The user must write registers over the APB port only while the block is idle; the
// block does not enforce it. Group id is at 0x0, node id 0x4, whitening mode 0x8, payload length 0xC.
// Reset clears the queue, the byte count and the registers (length reads back as 1).
module radio_packet_framer_crc16 import rpf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_payload_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_frame_byte,
  output logic              out_frame_end,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [7:0]       group_id_r;
  logic [4:0]       node_id_r;
  logic [1:0]       whitening_mode_r;
  logic [LEN_W-1:0] payload_length_r;
  logic [15:0]      group_crc_r;
  logic             wr_en;
  reg_idx_t         reg_idx;
  logic             push;
  logic             pop;
  logic             q_full;
  logic             head_valid;
  rpf_entry_t       push_entry;
  rpf_entry_t       head_entry;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign in_stall = q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_id_r <= '0;
      node_id_r <= '0;
      whitening_mode_r <= '0;
      payload_length_r <= LEN_W'(1);
      group_crc_r <= crc_fold(CRC_INIT, 8'h00);
    end else if (wr_en) begin
      case (reg_idx)
        REG_GROUP: begin
          group_id_r <= pwdata[7:0];
          group_crc_r <= crc_fold(CRC_INIT, pwdata[7:0]);
        end
        REG_NODE: node_id_r <= pwdata[4:0];
        REG_WHITE: whitening_mode_r <= pwdata[1:0];
        REG_LEN: payload_length_r <= pwdata[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GROUP: prdata = {24'h0, group_id_r};
      REG_NODE: prdata = {27'h0, node_id_r};
      REG_WHITE: prdata = {30'h0, whitening_mode_r};
      REG_LEN: prdata = {{(32 - LEN_W){1'b0}}, payload_length_r};
      default: prdata = '0;
    endcase
  end

  rpf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_payload_byte(in_payload_byte),
    .node_id        (node_id_r),
    .whitening_mode (whitening_mode_r),
    .payload_length (payload_length_r),
    .push           (push),
    .push_entry     (push_entry)
  );

  rpf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .full      (q_full),
    .head_valid(head_valid),
    .head_entry(head_entry)
  );

  rpf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (head_valid),
    .head_entry    (head_entry),
    .group_crc     (group_crc_r),
    .pop           (pop),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_frame_byte(out_frame_byte),
    .out_frame_end (out_frame_end)
  );

endmodule

// ===== sv/rpf_front.sv =====
// Front end: counts payload bytes, whitens them when whitening is on and classifies frame position.
module rpf_front import rpf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [7:0]       in_payload_byte,
  input  logic [4:0]       node_id,
  input  logic [1:0]       whitening_mode,
  input  logic [LEN_W-1:0] payload_length,
  output logic             push,
  output rpf_entry_t       push_entry
);

  logic [LEN_W-1:0] byte_count_r;
  logic [LEN_W-1:0] byte_count_nxt;
  logic [LEN_W-1:0] len_eff;
  logic             is_last;

  assign len_eff = eff_len(payload_length);
  assign is_last = (byte_count_r + LEN_W'(1)) >= len_eff;
  assign push = in_valid && !in_stall;

  always_comb begin
    push_entry.data  = (whitening_mode == WHITE_ON) ? (in_payload_byte ^ WHITE_MASK)
                                                   : in_payload_byte;
    push_entry.first = (byte_count_r == '0);
    push_entry.last  = is_last;
    push_entry.node  = node_id;
    push_entry.len   = len_eff;
  end

  always_comb begin
    byte_count_nxt = byte_count_r;
    if (push) begin
      byte_count_nxt = is_last ? '0 : byte_count_r + LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
    end else begin
      byte_count_r <= byte_count_nxt;
    end
  end

endmodule

// ===== sv/rpf_queue.sv =====
// Short item queue between the front end and the frame sequencer.
module rpf_queue import rpf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  rpf_entry_t push_entry,
  input  logic       pop,
  output logic       full,
  output logic       head_valid,
  output rpf_entry_t head_entry
);

  rpf_entry_t        mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QCNT_W-1:0] count_nxt;

  assign full = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("Queue written while full.");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("Queue read while empty.");

endmodule

// ===== sv/rpf_back.sv =====
// Back end: emits frame bytes one per cycle unless stalled and folds the node, length and data bytes into the CRC.
module rpf_back import rpf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  rpf_entry_t  head_entry,
  input  logic [15:0] group_crc,
  output logic        pop,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [7:0]  out_frame_byte,
  output logic        out_frame_end
);

  phase_t      phase_r;
  phase_t      phase_nxt;
  logic [15:0] crc_r;
  logic [15:0] crc_nxt;
  logic        out_valid_r;
  logic [7:0]  out_frame_byte_r;
  logic        out_frame_end_r;
  logic [7:0]  emit_byte;
  logic        emit_end;
  logic        go;

  assign go = head_valid && (!out_valid_r || !out_stall);

  always_comb begin
    phase_nxt = phase_r;
    crc_nxt = crc_r;
    emit_byte = head_entry.data;
    emit_end = 1'b0;
    pop = 1'b0;
    case (phase_r)
      PH_HEAD: begin
        if (head_entry.first) begin
          emit_byte = {3'b000, head_entry.node};
          crc_nxt = crc_fold(group_crc, {3'b000, head_entry.node});
          phase_nxt = PH_LEN;
        end else begin
          crc_nxt = crc_fold(crc_r, head_entry.data);
          if (head_entry.last) begin
            phase_nxt = PH_CRCL;
          end else begin
            pop = go;
          end
        end
      end
      PH_LEN: begin
        emit_byte = {1'b0, head_entry.len};
        crc_nxt = crc_fold(crc_r, {1'b0, head_entry.len});
        phase_nxt = PH_DATA;
      end
      PH_DATA: begin
        crc_nxt = crc_fold(crc_r, head_entry.data);
        if (head_entry.last) begin
          phase_nxt = PH_CRCL;
        end else begin
          phase_nxt = PH_HEAD;
          pop = go;
        end
      end
      PH_CRCL: begin
        emit_byte = crc_r[7:0];
        phase_nxt = PH_CRCH;
      end
      PH_CRCH: begin
        emit_byte = crc_r[15:8];
        phase_nxt = PH_POST1;
      end
      PH_POST1: begin
        emit_byte = POSTAMBLE;
        phase_nxt = PH_POST2;
      end
      PH_POST2: begin
        emit_byte = POSTAMBLE;
        emit_end = 1'b1;
        phase_nxt = PH_HEAD;
        pop = go;
      end
      default: begin
        phase_nxt = PH_HEAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEAD;
      out_valid_r <= 1'b0;
    end else begin
      if (go) begin
        phase_r <= phase_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      crc_r <= crc_nxt;
      out_frame_byte_r <= emit_byte;
      out_frame_end_r <= emit_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_frame_byte = out_frame_byte_r;
  assign out_frame_end = out_frame_end_r;

  a_head_held: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_HEAD) |-> head_valid)
    else $error("Frame in progress without a queued item.");

  a_end_pops: assert property (@(posedge clk) disable iff (!rst_n)
    (go && phase_r == PH_POST2) |-> pop)
    else $error("Final postamble byte did not release its item.");

  a_end_from_post: assert property (@(posedge clk) disable iff (!rst_n)
    (go && emit_end) |=> (out_valid && out_frame_end && $past(phase_r) == PH_POST2))
    else $error("Frame end flag raised outside the final postamble byte.");

endmodule
